### src/hwue_pkg.sv
// Package with the payload types, codes and state encoding of the weight update engine.
`default_nettype none
package hwue_pkg;

  typedef enum logic [1:0] {
    KIND_ACCUM  = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_EPOCH  = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_t;

  localparam logic [2:0] REG_RATE_INITIAL = 3'd0;
  localparam logic [2:0] REG_L2_DECAY     = 3'd1;
  localparam logic [2:0] REG_L1_DECAY     = 3'd2;
  localparam logic [2:0] REG_NORMALIZE    = 3'd3;
  localparam logic [2:0] REG_DECAY_INTVL  = 3'd4;
  localparam logic [2:0] REG_DECAY_FACTOR = 3'd5;

  localparam int CFG_W = 31;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         weight_index;
    logic signed [15:0] pre_activity;
    logic signed [15:0] post_activity;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] delta_out;
    logic [15:0]        count_out;
    logic [15:0]        rate_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DECAY,
    ST_SUM,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### src/hebbian_weight_update_engine_top.sv
// Top level of the Hebbian weight update engine with L1 and L2 weight decay.
//
// The engine holds a weight, a delta and an activation count for every entry in three
// synchronous memories. Items arrive on the in channel (in_valid / in_stall) as one
// packed struct; each item yields exactly one result on the out channel (out_valid /
// out_stall). A transfer takes place at a rising edge with valid high and stall low.
//
// One item is handled at a time. An item passes through the memory read, two multiply
// stages, a decay stage, a sum stage and the write back before its result is offered.
// A commit with normalisation and a nonzero count also runs the serial divider between
// the multiply and decay stages. The result waits in an output register while the
// receiver stalls, and the next item is taken no earlier than the cycle after that
// result has been transferred.
//
// After rst the engine sweeps the delta and count memories to zero, one entry a
// cycle, before the first item is accepted. Configuration writes are taken at any time
// on cfg_we / cfg_index / cfg_data; writing the initial rate also loads the current
// rate. The weight memory is not cleared.
`default_nettype none
module hebbian_weight_update_engine_top #(
  parameter int NUM_WEIGHTS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire hwue_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output hwue_pkg::out_item_t        out_data,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [hwue_pkg::CFG_W-1:0] cfg_data
);
  localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  // Configuration registers.
  logic [16:0] l2_decay;
  logic [30:0] l1_decay;
  logic        normalize_enable;
  logic [15:0] rate_decay_interval;
  logic [15:0] rate_decay_factor;
  logic [15:0] current_rate;
  logic [16:0] rate_timer;

  hwue_pkg::state_t state, state_next;
  hwue_pkg::in_item_t item;
  logic        ok;
  logic [AW-1:0] addr;
  logic [AW-1:0] clr_addr;

  // Memory ports.
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] w_wdata, d_wdata, w_rdata, d_rdata;
  logic [15:0] c_wdata, c_rdata;

  // Datapath registers.
  logic signed [31:0] w_q, d_q;
  logic [15:0]        c_q;
  logic signed [31:0] rp_q;     // rate * pre
  logic signed [47:0] prod_q;   // rate * pre * post
  logic signed [48:0] l2p_q;    // l2_decay * weight
  logic signed [31:0] dn_q;     // normalised delta
  logic signed [33:0] dec_q;    // d - l2 - l1
  logic signed [31:0] wn_q, dnew_q;
  logic [15:0]        cnew_q;
  logic               div_start, div_done;
  logic [31:0]        div_q;

  hwue_ram #(.WIDTH(32), .DEPTH(NUM_WEIGHTS)) u_wram (
    .clk, .we(mem_we && state != hwue_pkg::ST_CLEAR), .waddr(mem_waddr), .wdata(w_wdata),
    .raddr(addr), .rdata(w_rdata));
  hwue_ram #(.WIDTH(32), .DEPTH(NUM_WEIGHTS)) u_dram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(d_wdata), .raddr(addr), .rdata(d_rdata));
  hwue_ram #(.WIDTH(16), .DEPTH(NUM_WEIGHTS)) u_cram (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(c_wdata), .raddr(addr), .rdata(c_rdata));

  hwue_div u_div (
    .clk, .rst, .start(div_start), .dividend(d_q), .divisor(c_q),
    .done(div_done), .quotient(div_q));

  assign addr      = AW'(item.weight_index);
  assign mem_we    = (state == hwue_pkg::ST_CLEAR) || (state == hwue_pkg::ST_WRITE && ok &&
                     item.kind != hwue_pkg::KIND_EPOCH);
  assign mem_waddr = (state == hwue_pkg::ST_CLEAR) ? clr_addr : addr;
  assign w_wdata   = wn_q;
  assign d_wdata   = (state == hwue_pkg::ST_CLEAR) ? 32'd0 : dnew_q;
  assign c_wdata   = (state == hwue_pkg::ST_CLEAR) ? 16'd0 : cnew_q;
  assign in_stall  = (state != hwue_pkg::ST_IDLE);
  assign div_start = (state == hwue_pkg::ST_MUL2) && item.kind == hwue_pkg::KIND_COMMIT &&
                     normalize_enable && c_q != 16'd0;

  // Saturating helpers evaluated combinationally in the decay and sum stages.
  logic signed [34:0] acc_sum, wsum;
  logic signed [31:0] dsat;
  logic signed [47:0] inc;
  logic signed [32:0] l1t;
  logic signed [33:0] l1_term;
  logic signed [33:0] l2_term;

  assign inc     = prod_q >>> 28;
  assign acc_sum = 35'(d_q) + 35'(inc);
  assign dsat    = (dec_q > 34'sd2147483647) ? 32'sh7fffffff :
                   (dec_q < -34'sd2147483648) ? 32'sh80000000 : dec_q[31:0];
  assign wsum    = 35'(w_q) + 35'(dsat);
  assign l1t     = {2'b00, l1_decay};
  assign l1_term = (34'(w_q) > 34'(l1t)) ? 34'(l1t) :
                   (34'(w_q) < -34'(l1t)) ? -34'(l1t) : 34'(w_q);
  assign l2_term = 34'(l2p_q >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hwue_pkg::ST_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      l2_decay     <= '0;
      l1_decay     <= '0;
      normalize_enable    <= 1'b0;
      rate_decay_interval <= '0;
      rate_decay_factor   <= '0;
      current_rate <= '0;
      rate_timer   <= '0;
    end else begin
      state <= state_next;
      if (state == hwue_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          hwue_pkg::REG_RATE_INITIAL: begin
            current_rate <= cfg_data[15:0];
          end
          hwue_pkg::REG_L2_DECAY:
            l2_decay <= (cfg_data[16:0] > 17'd65536) ? 17'd65536 : cfg_data[16:0];
          hwue_pkg::REG_L1_DECAY:     l1_decay <= cfg_data[30:0];
          hwue_pkg::REG_NORMALIZE:    normalize_enable <= cfg_data[0];
          hwue_pkg::REG_DECAY_INTVL:  rate_decay_interval <= cfg_data[15:0];
          hwue_pkg::REG_DECAY_FACTOR: rate_decay_factor <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == hwue_pkg::ST_WRITE && item.kind == hwue_pkg::KIND_EPOCH &&
          rate_decay_interval != 16'd0) begin
        if (rate_timer == 17'd0) begin
          rate_timer   <= {1'b0, rate_decay_interval};
          current_rate <= prod_q[31:16];
        end else begin
          rate_timer <= rate_timer - 17'd1;
        end
      end
      if (state == hwue_pkg::ST_WRITE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    case (state)
      hwue_pkg::ST_IDLE: begin
        item <= in_data;
        ok   <= ({22'd0, in_data.weight_index} < 32'(NUM_WEIGHTS));
      end
      hwue_pkg::ST_MUL1: begin
        w_q <= w_rdata;
        d_q <= d_rdata;
        c_q <= c_rdata;
        if (item.kind == hwue_pkg::KIND_EPOCH) begin
          rp_q <= 32'({16'd0, current_rate} * (17'd65536 - {1'b0, rate_decay_factor}));
        end else begin
          rp_q <= 32'(signed'({1'b0, current_rate}) * item.pre_activity);
        end
      end
      hwue_pkg::ST_MUL2: begin
        if (item.kind == hwue_pkg::KIND_EPOCH) begin
          prod_q <= 48'(rp_q);
        end else begin
          prod_q <= 48'(rp_q * item.post_activity);
        end
        l2p_q <= 49'(signed'({1'b0, l2_decay}) * w_q);
        dn_q  <= (normalize_enable) ? 32'd0 : d_q;
      end
      hwue_pkg::ST_DIV: begin
        if (div_done) dn_q <= div_q;
      end
      hwue_pkg::ST_DECAY: begin
        dec_q <= 34'(dn_q) - l2_term - l1_term;
      end
      hwue_pkg::ST_SUM: begin
        wn_q   <= w_q;
        dnew_q <= d_q;
        cnew_q <= c_q;
        case (item.kind)
          hwue_pkg::KIND_ACCUM: begin
            if (item.pre_activity != 16'sd0) begin
              dnew_q <= (acc_sum > 35'sd2147483647) ? 32'sh7fffffff :
                        (acc_sum < -35'sd2147483648) ? 32'sh80000000 : acc_sum[31:0];
              cnew_q <= (c_q == 16'hffff) ? c_q : c_q + 16'd1;
            end
          end
          hwue_pkg::KIND_COMMIT: begin
            wn_q   <= (wsum > 35'sd2147483647) ? 32'sh7fffffff :
                      (wsum < -35'sd2147483648) ? 32'sh80000000 : wsum[31:0];
            dnew_q <= '0;
            cnew_q <= '0;
          end
          hwue_pkg::KIND_LOAD: wn_q <= item.load_value;
          default: ;
        endcase
      end
      default: ;
    endcase
    if (state == hwue_pkg::ST_WRITE) begin
      out_data.weight_out <= ok ? wn_q : 32'd0;
      out_data.delta_out  <= ok ? dnew_q : 32'd0;
      out_data.count_out  <= ok ? cnew_q : 16'd0;
      out_data.rate_out   <= (item.kind == hwue_pkg::KIND_EPOCH && rate_decay_interval != 16'd0
                              && rate_timer == 17'd0) ? prod_q[31:16] : current_rate;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hwue_pkg::ST_CLEAR:
        if (32'(clr_addr) == 32'(NUM_WEIGHTS - 1)) state_next = hwue_pkg::ST_IDLE;
      hwue_pkg::ST_IDLE:  if (in_valid) state_next = hwue_pkg::ST_READ;
      hwue_pkg::ST_READ:  state_next = hwue_pkg::ST_MUL1;
      hwue_pkg::ST_MUL1:  state_next = hwue_pkg::ST_MUL2;
      hwue_pkg::ST_MUL2:  state_next = div_start ? hwue_pkg::ST_DIV : hwue_pkg::ST_DECAY;
      hwue_pkg::ST_DIV:   if (div_done) state_next = hwue_pkg::ST_DECAY;
      hwue_pkg::ST_DECAY: state_next = hwue_pkg::ST_SUM;
      hwue_pkg::ST_SUM:   state_next = hwue_pkg::ST_WRITE;
      hwue_pkg::ST_WRITE: state_next = hwue_pkg::ST_OUT;
      hwue_pkg::ST_OUT:   if (!out_stall) state_next = hwue_pkg::ST_IDLE;
      default:            state_next = hwue_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/hwue_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none
module hwue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/hwue_div.sv
// Restoring divider for a signed 32-bit delta over a 16-bit count, one quotient bit a cycle.
`default_nettype none
module hwue_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] mag;
  logic [31:0] quo;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem, mag[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        neg  <= dividend[31];
        mag  <= dividend[31] ? (~dividend + 32'd1) : dividend;
        rem  <= '0;
        dvs  <= divisor;
        quo  <= '0;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[14:0], mag[31]};
          quo <= {quo[30:0], 1'b0};
        end
        mag <= {mag[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (~quo + 32'd1) : quo;
endmodule
`default_nettype wire

### src/hwue_checker.sv
// Port-level checker for the weight update engine, bound to the top level.
`default_nettype none
module hwue_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire hwue_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item taken while a result is pending");

  a_result_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result offered too early");
endmodule

bind hebbian_weight_update_engine_top hwue_checker u_hwue_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data);
`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the Hebbian weight update engine with L1 and L2 weight decay.
`timescale 1ns / 100ps
module tb;

  // Weight memory depth of the engine under test.
  localparam int NUM_ENTRIES = 1024;
  // Idle cycles waited after the last result before a configuration write or the end.
  localparam int DRAIN_CYCLES = 48;
  // The engine clears its delta and count memories after reset, so the limit on cycles
  // without any transfer must sit well above the time that the clear takes.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int POOL_SIZE = 24;

  // Scoreboard: a bit-accurate model of the engine and a queue of the results that
  // it predicts, checked in order as the engine offers them.
  class hebb_scoreboard;
    logic signed [31:0] weights [NUM_ENTRIES];
    logic signed [31:0] deltas [NUM_ENTRIES];
    logic [15:0]        counts [NUM_ENTRIES];
    logic [15:0]        rate;
    int                 epoch_timer;
    logic [15:0]        rate_init;
    longint             l2_factor;
    longint             l1_step;
    bit                 norm_on;
    int                 decay_interval;
    longint             decay_factor;
    hwue_pkg::out_item_t pending [$];
    int                 mismatches;

    function new();
      foreach (weights[i]) begin
        weights[i] = '0;
        deltas[i]  = '0;
        counts[i]  = '0;
      end
      rate = '0;
      epoch_timer = 0;
      rate_init = '0;
      l2_factor = 0;
      l1_step = 0;
      norm_on = 0;
      decay_interval = 0;
      decay_factor = 0;
      mismatches = 0;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void write_reg(logic [2:0] idx, logic [hwue_pkg::CFG_W-1:0] v);
      case (idx)
        hwue_pkg::REG_RATE_INITIAL: begin
          rate_init = v[15:0];
          rate = v[15:0];
        end
        hwue_pkg::REG_L2_DECAY: begin
          l2_factor = longint'(v[16:0]);
          if (l2_factor > 65536) l2_factor = 65536;
        end
        hwue_pkg::REG_L1_DECAY:     l1_step = longint'(v[30:0]);
        hwue_pkg::REG_NORMALIZE:    norm_on = v[0];
        hwue_pkg::REG_DECAY_INTVL:  decay_interval = int'(v[15:0]);
        hwue_pkg::REG_DECAY_FACTOR: decay_factor = longint'(v[15:0]);
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_input(hwue_pkg::in_item_t it);
      int        i;
      longint    prod;
      longint    w;
      longint    d;
      longint    l2_term;
      longint    l1_term;
      hwue_pkg::out_item_t res;
      i = int'(it.weight_index);
      if (it.kind == hwue_pkg::KIND_EPOCH) begin
        if (decay_interval > 0) begin
          epoch_timer = epoch_timer - 1;
          if (epoch_timer < 0) begin
            epoch_timer = decay_interval;
            rate = 16'((longint'(rate) * (65536 - decay_factor)) >> 16);
          end
        end
      end else if (it.kind == hwue_pkg::KIND_ACCUM) begin
        if (it.pre_activity != 0) begin
          prod = longint'(rate) * longint'(it.pre_activity) * longint'(it.post_activity);
          deltas[i] = sat32(longint'(deltas[i]) + (prod >>> 28));
          if (counts[i] != 16'hffff) counts[i] = counts[i] + 16'd1;
        end
      end else if (it.kind == hwue_pkg::KIND_COMMIT) begin
        w = longint'(weights[i]);
        d = longint'(deltas[i]);
        if (norm_on) begin
          if (counts[i] == 0) d = 0;
          else d = d / longint'(counts[i]);
        end
        l2_term = (l2_factor * w) >>> 16;
        if (w > l1_step) l1_term = l1_step;
        else if (w < -l1_step) l1_term = -l1_step;
        else l1_term = w;
        weights[i] = sat32(w + longint'(sat32(d - l2_term - l1_term)));
        deltas[i] = '0;
        counts[i] = '0;
      end else begin
        weights[i] = it.load_value;
      end
      res.weight_out = weights[i];
      res.delta_out  = deltas[i];
      res.count_out  = counts[i];
      res.rate_out   = rate;
      pending = {pending, res};
    endfunction

    function void check_result(hwue_pkg::out_item_t got);
      hwue_pkg::out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: weight %0d delta %0d count %0d rate %0d",
                   got.weight_out, got.delta_out, got.count_out, got.rate_out);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: weight %0d/%0d delta %0d/%0d count %0d/%0d rate %0d/%0d",
                   want.weight_out, got.weight_out, want.delta_out, got.delta_out,
                   want.count_out, got.count_out, want.rate_out, got.rate_out);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  hwue_pkg::in_item_t  in_data;
  logic             out_valid;
  logic             out_stall;
  hwue_pkg::out_item_t out_data;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [hwue_pkg::CFG_W-1:0] cfg_data;

  hebbian_weight_update_engine_top #(.NUM_WEIGHTS(NUM_ENTRIES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hebb_scoreboard sb;
  // Percentage of cycles in which the sender withholds an item or the receiver stalls.
  int send_idle;
  int recv_idle;
  int quiet_cycles;
  // Entries that have been given a weight; reading any other entry is outside the contract.
  bit written [NUM_ENTRIES];
  logic [9:0] pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input starts at a known value before the first edge.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_idle = 0;
    sb = new();
  end

  // Receiver: the stall is chosen at the falling edge and a result is taken at the
  // rising edge where it is offered while the stall is low.
  initial begin
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_idle);
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog: ends the run if no transfer on either channel happens for too long.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offers one item, holding it steady until the engine takes the transfer.
  task automatic send_item(hwue_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    written[it.weight_index] = 1'b1;
  endtask

  function automatic hwue_pkg::in_item_t make_item(logic [1:0] kind, logic [9:0] idx,
                                                   logic [15:0] pre, logic [15:0] post,
                                                   logic [31:0] val);
    hwue_pkg::in_item_t it;
    it.kind = kind;
    it.weight_index = idx;
    it.pre_activity = pre;
    it.post_activity = post;
    it.load_value = val;
    return it;
  endfunction

  // Registers are written only once the engine has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [hwue_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.write_reg(idx, v);
  endtask

  task automatic configure(logic [15:0] r0, logic [16:0] l2, logic [30:0] l1, bit nrm,
                           logic [15:0] intvl, logic [15:0] fac);
    write_cfg(hwue_pkg::REG_RATE_INITIAL, hwue_pkg::CFG_W'(r0));
    write_cfg(hwue_pkg::REG_L2_DECAY, hwue_pkg::CFG_W'(l2));
    write_cfg(hwue_pkg::REG_L1_DECAY, l1);
    write_cfg(hwue_pkg::REG_NORMALIZE, hwue_pkg::CFG_W'(nrm));
    write_cfg(hwue_pkg::REG_DECAY_INTVL, hwue_pkg::CFG_W'(intvl));
    write_cfg(hwue_pkg::REG_DECAY_FACTOR, hwue_pkg::CFG_W'(fac));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [15:0] pick_activity();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom);
      default: return 32'($signed(21'($urandom)));
    endcase
  endfunction

  // Random item on a small pool of entries so that deltas build up before commits.
  // An entry with no weight yet is always loaded first.
  function automatic hwue_pkg::in_item_t random_item();
    logic [9:0]  idx;
    logic [1:0]  kind;
    int          roll;
    if ($urandom_range(99) < 4) idx = 10'($urandom);
    else idx = pool[$urandom_range(POOL_SIZE - 1)];
    roll = $urandom_range(99);
    if (!written[idx]) kind = hwue_pkg::KIND_LOAD;
    else if (roll < 50) kind = hwue_pkg::KIND_ACCUM;
    else if (roll < 70) kind = hwue_pkg::KIND_COMMIT;
    else if (roll < 85) kind = hwue_pkg::KIND_EPOCH;
    else kind = hwue_pkg::KIND_LOAD;
    return make_item(kind, idx, pick_activity(), pick_activity(), pick_weight());
  endfunction

  initial begin
    foreach (written[i]) written[i] = 1'b0;
    pool[0] = 10'd0;
    pool[1] = 10'd1023;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = 10'($urandom);
    #1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: full rate, L2 written above one so it clamps, normalisation on,
    // and a rate decay on every second epoch.
    configure(16'hffff, 17'h1ffff, 31'h0000_1000, 1'b1, 16'd1, 16'h8000);
    send_item(make_item(hwue_pkg::KIND_LOAD, 10'd0, 16'h0, 16'h0, 32'h7fffffff));
    send_item(make_item(hwue_pkg::KIND_LOAD, 10'd1023, 16'h0, 16'h0, 32'h80000000));
    send_item(make_item(hwue_pkg::KIND_LOAD, 10'd5, 16'h0, 16'h0, 32'h0));
    send_item(make_item(hwue_pkg::KIND_LOAD, 10'd7, 16'h0, 16'h0, 32'h0000_0800));
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd0, 16'h8000, 16'h8000, 32'h0));
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd0, 16'h7fff, 16'h8000, 32'h0));
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd0, 16'h0000, 16'h7fff, 32'h0));
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd0, 16'hffff, 16'h0001, 32'h0));
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd1023, 16'h8000, 16'h7fff, 32'h0));
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd0, 16'h0, 16'h0, 32'h0));
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd1023, 16'h0, 16'h0, 32'h0));
    // Commit with a zero count under normalisation, and a weight inside the L1 band.
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd5, 16'h0, 16'h0, 32'h0));
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd7, 16'h0, 16'h0, 32'h0));
    repeat (4) send_item(make_item(hwue_pkg::KIND_EPOCH, 10'd5, 16'h0, 16'h0, 32'h0));
    settle();

    // Zero rate, no L2 or rate decay, the largest L1 step, normalisation off.
    configure(16'h0000, 17'd0, 31'h7fffffff, 1'b0, 16'd0, 16'h0000);
    send_item(make_item(hwue_pkg::KIND_ACCUM, 10'd0, 16'h7fff, 16'h7fff, 32'h0));
    send_item(make_item(hwue_pkg::KIND_EPOCH, 10'd0, 16'h0, 16'h0, 32'h0));
    send_item(make_item(hwue_pkg::KIND_LOAD, 10'd0, 16'h0, 16'h0, 32'h7fffffff));
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd0, 16'h0, 16'h0, 32'h0));
    send_item(make_item(hwue_pkg::KIND_COMMIT, 10'd1023, 16'h0, 16'h0, 32'h0));
    settle();

    // Random part in six phases: two per idling pattern, each with fresh settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle = 8;  recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 8;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 3)
        configure(16'hffff, 17'd65536, 31'd0, 1'b1, 16'hffff, 16'hffff);
      else
        configure(16'($urandom), 17'($urandom_range(70000)),
                  ($urandom_range(1) != 0) ? 31'($urandom) : 31'($urandom_range(1 << 18)),
                  1'($urandom), 16'($urandom_range(3)), 16'($urandom));
      repeat (105) send_item(random_item());
      settle();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/hwue_pkg.sv
src/hwue_ram.sv
src/hwue_div.sv
src/hebbian_weight_update_engine_top.sv
src/hwue_checker.sv
dv/tb.sv
